[design/ptmt_pkg.sv]
// ----------------------------------------------------------------------------
// Package for the power telemetry median tracker
// Shared widths, depths and the controller-to-datapath command and status types.
// ----------------------------------------------------------------------------
package ptmt_pkg;

  localparam int WindowDepth = 16;
  localparam int IdxW        = $clog2(WindowDepth);
  localparam int FillW       = $clog2(WindowDepth + 1);
  localparam int PowerW      = 16;
  localparam int TimeW       = 48;
  localparam int EpochW      = 32;
  localparam int ProgW       = 17;
  localparam int RollW       = 24;
  localparam int TotalW      = 40;
  localparam int MidHi       = WindowDepth / 2;
  localparam int MidLo       = (WindowDepth % 2 == 1) ? MidHi : MidHi - 1;
  localparam int InDataW     = 152;
  localparam int OutDataW    = 208;

  typedef struct packed {
    logic              load;
    logic              outer_step;
    logic              inner_step;
    logic [IdxW-1:0]   outer_idx;
    logic [IdxW-1:0]   inner_idx;
    logic              finish;
  } ptmt_cmd_t;

  typedef struct packed {
    logic full;
  } ptmt_sts_t;

endpackage

[design/ptmt_ctrl.sv]
// ----------------------------------------------------------------------------
// Median tracker controller
// Sequences intake, the rank count over the window and result delivery.
// ----------------------------------------------------------------------------
module ptmt_ctrl
  import ptmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  ptmt_sts_t sts,
  output ptmt_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_RANK, S_OUT} state_t;

  state_t          state_r, state_nxt;
  logic [IdxW-1:0] oi_r, oi_nxt, ii_r, ii_nxt;

  always_comb begin
    state_nxt = state_r;
    oi_nxt = oi_r;
    ii_nxt = ii_r;
    cmd = '0;
    cmd.outer_idx = oi_r;
    cmd.inner_idx = ii_r;
    in_tready = (state_r == S_IDLE);
    out_tvalid = (state_r == S_OUT);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        oi_nxt = '0;
        ii_nxt = '0;
        state_nxt = sts.full ? S_RANK : S_IDLE;
      end
      S_RANK: begin
        cmd.inner_step = 1'b1;
        ii_nxt = ii_r + 1'b1;
        if (ii_r == IdxW'(WindowDepth - 1)) begin
          cmd.outer_step = 1'b1;
          ii_nxt = '0;
          oi_nxt = oi_r + 1'b1;
          if (oi_r == IdxW'(WindowDepth - 1)) begin
            cmd.finish = 1'b1;
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      oi_r <= '0;
      ii_r <= '0;
    end else begin
      state_r <= state_nxt;
      oi_r <= oi_nxt;
      ii_r <= ii_nxt;
    end
  end

endmodule

[design/ptmt_dp.sv]
// ----------------------------------------------------------------------------
// Median tracker datapath
// Holds the window, progress and epoch state and finds the middle ranks.
// ----------------------------------------------------------------------------
module ptmt_dp
  import ptmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [InDataW-1:0]  in_tdata,
  input  ptmt_cmd_t           cmd,
  output ptmt_sts_t           sts,
  output logic [OutDataW-1:0] out_tdata
);

  logic [PowerW-1:0] ring_r [WindowDepth];
  logic [IdxW-1:0]   wp_r;
  logic [FillW-1:0]  fill_r;
  logic [ProgW-1:0]  prev_prog_r;
  logic              prev_ok_r;
  logic [RollW-1:0]  roll_r;
  logic [EpochW-1:0] rep_epoch_r;
  logic [TimeW-1:0]  rep_etime_r;
  logic [TotalW-1:0] rep_prog_r;
  logic [TimeW-1:0]  rep_ptime_r;
  logic [PowerW-1:0] budget_r, enf_r, lo_val_r, hi_val_r;
  logic [TimeW-1:0]  now_r;
  logic [EpochW-1:0] epoch_r;
  logic [ProgW-1:0]  prog_r;
  logic              prog_ok_r;
  logic [IdxW:0]     less_r, leq_r;

  logic [PowerW-1:0] p, vo, vi, med;
  logic              pv, qv;
  logic [ProgW-1:0]  q;
  logic [IdxW:0]     less_f, leq_f;
  logic [TotalW:0]   total;
  logic [PowerW:0]   sum;

  assign p  = in_tdata[15:0];
  assign pv = in_tdata[16];
  assign q  = in_tdata[145:129];
  assign qv = in_tdata[146];
  assign vo = ring_r[cmd.outer_idx];
  assign vi = ring_r[cmd.inner_idx];
  assign less_f = less_r + (IdxW+1)'(vi < vo);
  assign leq_f  = leq_r + (IdxW+1)'(vi <= vo);
  assign sts.full = (fill_r == FillW'(WindowDepth));
  assign total = {1'b0, roll_r, 16'd0} + (TotalW+1)'(prog_r);
  assign sum = {1'b0, lo_val_r} + {1'b0, hi_val_r};
  assign med = sum[PowerW:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      fill_r <= '0;
      prev_prog_r <= '0;
      prev_ok_r <= 1'b1;
      roll_r <= '0;
      rep_epoch_r <= '0;
      rep_etime_r <= '0;
      rep_prog_r <= '0;
      rep_ptime_r <= '0;
    end else if (cmd.load) begin
      if (prev_ok_r && qv && prev_prog_r > q && roll_r != '1) roll_r <= roll_r + 1'b1;
      prev_prog_r <= qv ? q : '0;
      prev_ok_r <= qv;
      if (pv) begin
        wp_r <= (wp_r == IdxW'(WindowDepth - 1)) ? '0 : wp_r + 1'b1;
        if (fill_r != FillW'(WindowDepth)) fill_r <= fill_r + 1'b1;
      end
    end else if (cmd.finish) begin
      if (epoch_r != rep_epoch_r) begin
        rep_epoch_r <= epoch_r;
        rep_etime_r <= now_r;
      end
      if (prog_ok_r) begin
        if (total[TotalW] || total[TotalW-1:0] != rep_prog_r) begin
          rep_prog_r <= total[TotalW] ? '1 : total[TotalW-1:0];
          rep_ptime_r <= now_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (pv) ring_r[wp_r] <= p;
      budget_r <= in_tdata[32:17];
      enf_r <= in_tdata[48:33];
      now_r <= in_tdata[96:49];
      epoch_r <= in_tdata[128:97];
      prog_r <= q;
      prog_ok_r <= qv;
      less_r <= '0;
      leq_r <= '0;
    end else if (cmd.inner_step) begin
      if (cmd.outer_step) begin
        if (less_f <= (IdxW+1)'(MidLo) && leq_f > (IdxW+1)'(MidLo)) lo_val_r <= vo;
        if (less_f <= (IdxW+1)'(MidHi) && leq_f > (IdxW+1)'(MidHi)) hi_val_r <= vo;
        less_r <= '0;
        leq_r <= '0;
      end else begin
        less_r <= less_f;
        leq_r <= leq_f;
      end
    end
  end

  assign out_tdata = {7'b0, rep_ptime_r, rep_prog_r, rep_etime_r, rep_epoch_r,
                      enf_r, (med <= budget_r), med};

endmodule

[design/power_telemetry_median_tracker.sv]
// ----------------------------------------------------------------------------
// Power telemetry median tracker
// Tracks the median of the last sixteen valid power samples and reports
// epoch and progress changes on every tick once the window is full.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// in_     | slave     | one telemetry tick
// out_    | master    | median, convergence, epoch and progress report
//
// A tick that emits ranks every window entry against the whole window before
// delivery: the rank count compares one pair of window entries per cycle.
// A tick that does not emit passes only through intake and the fullness check.
// Reset is synchronous and active low; the window needs no clearing.
// A stalled result holds the block until it is taken.
module power_telemetry_median_tracker
  import ptmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // power_sample, power_valid, budget, enforced_power, timestamp,
  // epoch_cnt, prog_frac, progress_valid
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // median_power, converged, enforced_power_out, epoch_out,
  // epoch_since, progress_total, prog_since
  output logic [OutDataW-1:0] out_tdata
);

  ptmt_cmd_t cmd;
  ptmt_sts_t sts;

  ptmt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .sts(sts), .cmd(cmd)
  );

  ptmt_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_tdata(in_tdata), .cmd(cmd), .sts(sts),
    .out_tdata(out_tdata)
  );

endmodule

[bench/power_telemetry_median_tracker_tb.sv]
// ----------------------------------------------------------------------------
// Testbench for the power telemetry median tracker
// Drives telemetry ticks with random idling on both sides, predicts each
// report from a behavioral model of the window, the rollover count and the
// epoch and progress tracking, and checks every report field by field.
// ----------------------------------------------------------------------------
module power_telemetry_median_tracker_tb;
  import ptmt_pkg::*;

  typedef struct packed {
    logic [15:0] power_sample;
    logic        power_valid;
    logic [15:0] budget;
    logic [15:0] enforced_power;
    logic [47:0] timestamp;
    logic [31:0] epoch_cnt;
    logic [16:0] prog_frac;
    logic        progress_valid;
  } tick_t;

  typedef struct packed {
    logic [15:0] median_power;
    logic        converged;
    logic [15:0] enforced_power_out;
    logic [31:0] epoch_out;
    logic [47:0] epoch_since;
    logic [39:0] progress_total;
    logic [47:0] prog_since;
  } report_t;

  class median_scoreboard;
    logic [15:0] window [WindowDepth];
    int          wr_ptr;
    int          fill;
    logic [16:0] last_prog;
    logic        last_prog_ok;
    logic [23:0] rollovers;
    logic [31:0] epoch_seen;
    logic [47:0] epoch_time;
    logic [39:0] prog_seen;
    logic [47:0] prog_time;
    report_t     pending [$];
    int          errors;
    int          seen;

    function new();
      wr_ptr = 0; fill = 0; last_prog = '0; last_prog_ok = 1'b1;
      rollovers = '0; epoch_seen = '0; epoch_time = '0;
      prog_seen = '0; prog_time = '0; errors = 0; seen = 0;
    endfunction

    function logic [15:0] window_median();
      logic [15:0] s [WindowDepth];
      logic [15:0] t;
      s = window;
      for (int i = 1; i < WindowDepth; i++) begin
        for (int j = i; j > 0 && s[j-1] > s[j]; j--) begin
          t = s[j]; s[j] = s[j-1]; s[j-1] = t;
        end
      end
      return 16'(({1'b0, s[MidLo]} + {1'b0, s[MidHi]}) >> 1);
    endfunction

    function void note_tick(tick_t k);
      report_t r;
      logic [40:0] total;
      if (last_prog_ok && k.progress_valid && last_prog > k.prog_frac &&
          rollovers != 24'hFFFFFF) begin
        rollovers++;
      end
      last_prog    = k.progress_valid ? k.prog_frac : '0;
      last_prog_ok = k.progress_valid;
      if (k.power_valid) begin
        window[wr_ptr] = k.power_sample;
        wr_ptr = (wr_ptr + 1) % WindowDepth;
        if (fill < WindowDepth) begin
          fill++;
        end
      end
      if (fill < WindowDepth) begin
        return;
      end
      r.median_power = window_median();
      if (k.epoch_cnt != epoch_seen) begin
        epoch_seen = k.epoch_cnt;
        epoch_time = k.timestamp;
      end
      if (k.progress_valid) begin
        total = {1'b0, rollovers, 16'h0} + 41'(k.prog_frac);
        if (total[40]) begin
          total = {1'b0, 40'hFF_FFFF_FFFF};
        end
        if (total[39:0] != prog_seen) begin
          prog_seen = total[39:0];
          prog_time = k.timestamp;
        end
      end
      r.converged          = r.median_power <= k.budget;
      r.enforced_power_out = k.enforced_power;
      r.epoch_out          = epoch_seen;
      r.epoch_since        = epoch_time;
      r.progress_total     = prog_seen;
      r.prog_since         = prog_time;
      pending.push_back(r);
    endfunction

    function void check_report(report_t a);
      report_t e;
      seen++;
      if (pending.size() == 0) begin
        $error("unexpected report %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.median_power != e.median_power) begin
        $error("median_power exp %0d got %0d", e.median_power, a.median_power);
        errors++;
      end
      if (a.converged != e.converged) begin
        $error("converged exp %0d got %0d", e.converged, a.converged);
        errors++;
      end
      if (a.enforced_power_out != e.enforced_power_out) begin
        $error("enforced_power_out exp %0d got %0d", e.enforced_power_out,
               a.enforced_power_out);
        errors++;
      end
      if (a.epoch_out != e.epoch_out) begin
        $error("epoch_out exp %0d got %0d", e.epoch_out, a.epoch_out);
        errors++;
      end
      if (a.epoch_since != e.epoch_since) begin
        $error("epoch_since exp %0d got %0d", e.epoch_since, a.epoch_since);
        errors++;
      end
      if (a.progress_total != e.progress_total) begin
        $error("progress_total exp %0d got %0d", e.progress_total, a.progress_total);
        errors++;
      end
      if (a.prog_since != e.prog_since) begin
        $error("prog_since exp %0d got %0d", e.prog_since, a.prog_since);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  // power_sample, power_valid, budget, enforced_power, timestamp,
  // epoch_cnt, prog_frac, progress_valid
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  // median_power, converged, enforced_power_out, epoch_out,
  // epoch_since, progress_total, prog_since
  logic [OutDataW-1:0] out_tdata;

  median_scoreboard sb;
  bit               calm;
  bit               hold_off;
  bit               feeding_done;
  logic [47:0]      clock_us;
  logic [31:0]      epoch_now;
  logic [16:0]      prog_now;

  power_telemetry_median_tracker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [InDataW-1:0] pack_tick(tick_t k);
    return {5'b0, k.progress_valid, k.prog_frac, k.epoch_cnt, k.timestamp,
            k.enforced_power, k.budget, k.power_valid, k.power_sample};
  endfunction

  function automatic report_t unpack_report(logic [OutDataW-1:0] d);
    report_t r;
    r.median_power       = d[15:0];
    r.converged          = d[16];
    r.enforced_power_out = d[32:17];
    r.epoch_out          = d[64:33];
    r.epoch_since        = d[112:65];
    r.progress_total     = d[152:113];
    r.prog_since         = d[200:153];
    return r;
  endfunction

  task automatic send_tick(tick_t k);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_tick(k);
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    sb.note_tick(k);
  endtask

  function automatic logic [15:0] pick_power();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(900, 1100));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed telemetry: rising time, slowly advancing epochs,
  // progress that climbs and wraps, with occasional invalid fields.
  function automatic tick_t next_tick();
    tick_t k;
    clock_us = clock_us + 48'($urandom_range(1, 2000));
    if ($urandom_range(0, 19) == 0) begin
      clock_us = 48'({$urandom, $urandom});
    end
    if ($urandom_range(0, 5) == 0) begin
      epoch_now = epoch_now + 1;
    end
    if ($urandom_range(0, 29) == 0) begin
      epoch_now = $urandom;
    end
    prog_now = prog_now + 17'($urandom_range(0, 12000));
    if (prog_now > 17'd65536) begin
      prog_now = 17'($urandom_range(0, 3000));
    end
    k.power_sample   = pick_power();
    k.power_valid    = $urandom_range(0, 9) != 0;
    k.budget         = $urandom_range(0, 1) ? 16'($urandom_range(800, 1200))
                                            : 16'($urandom);
    k.enforced_power = 16'($urandom);
    k.timestamp      = clock_us;
    k.epoch_cnt      = epoch_now;
    k.prog_frac      = ($urandom_range(0, 19) == 0) ? 17'($urandom) : prog_now;
    k.progress_valid = $urandom_range(0, 11) != 0;
    return k;
  endfunction

  // Directed start: fill the window with extremes, invalid power, progress
  // wraps and invalid progress, epoch changes and full-width fields.
  task automatic directed_ticks();
    tick_t k;
    for (int i = 0; i < 24; i++) begin
      k.power_sample   = (i % 3 == 0) ? 16'hFFFF : (i % 3 == 1) ? 16'h0 : 16'(i * 1000);
      k.power_valid    = (i != 5 && i != 19);
      k.budget         = (i % 2) ? 16'hFFFF : 16'h0;
      k.enforced_power = (i % 2) ? 16'hFFFF : 16'h0;
      k.timestamp      = (i == 20) ? 48'hFFFF_FFFF_FFFF : 48'(i * 100 + 7);
      k.epoch_cnt      = (i == 21) ? 32'hFFFF_FFFF : 32'(i / 4);
      k.prog_frac      = (i % 4 == 0) ? 17'h1FFFF : (i % 4 == 1) ? 17'd65536
                       : (i % 4 == 2) ? 17'd0 : 17'd40000;
      k.progress_valid = (i != 9 && i != 18);
      send_tick(k);
    end
  endtask

  initial begin
    tick_t k;
    sb           = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    calm         = 1'b0;
    feeding_done = 1'b0;
    clock_us     = 48'd5000;
    epoch_now    = '0;
    prog_now     = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_ticks();
    // Random ticks, with a stretch of forced progress wraps to step the rollover count.
    for (int i = 0; i < 1520; i++) begin
      if (i == 1300) begin
        calm = 1'b1;
      end
      k = next_tick();
      if (i >= 600 && i < 700) begin
        k.prog_frac      = (i % 2) ? 17'h1FFFF : 17'd0;
        k.progress_valid = 1'b1;
      end
      send_tick(k);
    end
    in_tvalid <= 1'b0;
    feeding_done = 1'b1;
  end

  initial begin
    int gap;
    out_tready = 1'b0;
    hold_off   = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_report(unpack_report(out_tdata));
      end
      if (!hold_off && sb.seen >= 200) begin
        hold_off = 1'b1;
        out_tready <= 1'b0;
        gap = 3000;
        repeat (gap) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        gap = $urandom_range(1, 17);
        repeat (gap) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    wait (feeding_done);
    while (sb.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (600) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("power_telemetry_median_tracker_tb passed");
    end else begin
      $display("power_telemetry_median_tracker_tb failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("power_telemetry_median_tracker_tb failed");
    $finish;
  end

endmodule
